// File: hdl/tga_rle_pixel_decoder_defines.svh
// Assertion macros used by the TGA pixel decoder back end.
// No dependencies; include this file inside a module body.
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define TGA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tga decoder assertion failed");

// Next-cycle implication, disabled while reset is active.
`define TGA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tga decoder assertion failed");

`endif

// File: hdl/tga_pkg.sv
// Shared types and constants of the TGA pixel decoder.
// No dependencies; imported by every module of the decoder.
`timescale 1ns / 1ps
package tga_pkg;

    localparam int CfgIdxW    = 2;
    localparam int CfgDataW   = 16;
    localparam int QueueDepth = 2;

    localparam logic [CfgIdxW-1:0] RegRleMode  = 2'd0;
    localparam logic [CfgIdxW-1:0] RegBpp      = 2'd1;
    localparam logic [CfgIdxW-1:0] RegWidth    = 2'd2;
    localparam logic [CfgIdxW-1:0] RegHeight   = 2'd3;

    localparam logic [2:0] Bpp3       = 3'd3;
    localparam logic [2:0] Bpp4       = 3'd4;
    localparam logic [2:0] BppReset   = Bpp4;
    localparam logic [7:0] AlphaOpaque = 8'hFF;

    typedef struct packed {
        logic       rle;
        logic [2:0] bpp;
    } t_cfg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       run;
        logic [7:0] count;
    } t_evt;

endpackage

// File: hdl/tga_rle_pixel_decoder.sv
// TGA truecolor pixel decoder: takes one pixel-data byte per cycle and returns RGBA pixels,
// in raw or run-length mode, with a repeat count per pixel and an end-of-image flag. The
// decoder accepts a byte every cycle while the output side keeps up; a pixel enters the
// two-entry request queue at the clock edge that accepts its last byte and moves into the
// output register once the output stage is free; the queue lets the byte front end and the
// output stage stall independently. Once two pixels wait in the queue behind a held output,
// the input stalls until the output takes one. Any register write restarts decoding; the
// pixel total is a 16x16 product loaded at that write.
// Depends on tga_pkg, tga_front, tga_fifo and tga_back.
`timescale 1ns / 1ps
module tga_rle_pixel_decoder import tga_pkg::*; #(
    parameter int QUEUE_DEPTH = QueueDepth
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [7:0]          s_axis_tdata,   // data_byte
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [39:0]         m_axis_tdata,   // red, green, blue, alpha, repeat_res
    output logic                m_axis_tlast    // image_done
);

    t_cfg        r_cfg, n_cfg;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [31:0] n_total;
    logic        push, pop, full, empty;
    t_evt        front_evt, queue_evt;

    always_comb begin
        n_cfg    = r_cfg;
        n_width  = r_width;
        n_height = r_height;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                RegRleMode: n_cfg.rle = i_cfg_wdata[0];
                RegBpp:     n_cfg.bpp = i_cfg_wdata[2:0];
                RegWidth:   n_width   = i_cfg_wdata[15:0];
                RegHeight:  n_height  = i_cfg_wdata[15:0];
                default:    n_cfg     = r_cfg;
            endcase
        end
    end

    assign n_total = {16'd0, n_width} * {16'd0, n_height};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rle <= 1'b0;
            r_cfg.bpp <= BppReset;
            r_width   <= 16'd0;
            r_height  <= 16'd0;
        end else begin
            r_cfg    <= n_cfg;
            r_width  <= n_width;
            r_height <= n_height;
        end
    end

    tga_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (i_cfg_we),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .i_byte    (s_axis_tdata),
        .i_full    (full),
        .o_ready   (s_axis_tready),
        .o_push    (push),
        .o_evt     (front_evt)
    );

    tga_fifo #(
        .Depth (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (i_cfg_we),
        .i_push  (push),
        .i_data  (front_evt),
        .i_pop   (pop),
        .o_data  (queue_evt),
        .o_full  (full),
        .o_empty (empty)
    );

    tga_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (i_cfg_we),
        .i_total     (n_total),
        .i_empty     (empty),
        .i_evt       (queue_evt),
        .o_pop       (pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_last  (m_axis_tlast)
    );

endmodule

// File: hdl/tga_front.sv
// Byte front end: packet headers, pixel assembly and color decode.
// Depends on tga_pkg; feeds decoded pixel requests to tga_fifo.
`timescale 1ns / 1ps
module tga_front import tga_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_restart,
    input  t_cfg       i_cfg,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_full,
    output logic       o_ready,
    output logic       o_push,
    output t_evt       o_evt
);

    logic        r_expect_header, n_expect_header;
    logic        r_is_run, n_is_run;
    logic [7:0]  r_left, n_left;
    logic [1:0]  r_pos, n_pos;
    logic [23:0] r_partial, n_partial;
    logic        take;
    logic [1:0]  last_idx;
    logic        is_header;
    logic        is_last;
    logic [7:0]  p0, p1, p2;

    assign o_ready   = !i_full;
    assign take      = i_valid && !i_full;
    assign last_idx  = (i_cfg.bpp == Bpp4) ? 2'd3 : ((i_cfg.bpp == Bpp3) ? 2'd2 : 2'd1);
    assign is_header = i_cfg.rle && r_expect_header;
    assign is_last   = !is_header && (r_pos >= last_idx);
    assign o_push    = take && is_last;
    assign p0 = r_partial[7:0];
    assign p1 = r_partial[15:8];
    assign p2 = r_partial[23:16];

    always_comb begin
        o_evt.run   = i_cfg.rle && r_is_run;
        o_evt.count = r_left;
        if (i_cfg.bpp == Bpp4) begin
            o_evt.red   = p2;
            o_evt.green = p1;
            o_evt.blue  = p0;
            o_evt.alpha = i_byte;
        end else if (i_cfg.bpp == Bpp3) begin
            o_evt.red   = i_byte;
            o_evt.green = p1;
            o_evt.blue  = p0;
            o_evt.alpha = AlphaOpaque;
        end else begin
            o_evt.red   = {i_byte[6:2], 3'b000};
            o_evt.green = {i_byte[1:0], p0[7:5], 3'b000};
            o_evt.blue  = {p0[4:0], 3'b000};
            o_evt.alpha = {i_byte[7], 7'b0000000};
        end
    end

    always_comb begin
        n_expect_header = r_expect_header;
        n_is_run        = r_is_run;
        n_left          = r_left;
        n_pos           = r_pos;
        n_partial       = r_partial;
        if (take) begin
            if (is_header) begin
                n_is_run        = i_byte[7];
                n_left          = {1'b0, i_byte[6:0]} + 8'd1;
                n_expect_header = 1'b0;
                n_pos           = 2'd0;
            end else if (!is_last) begin
                case (r_pos)
                    2'd0: n_partial[7:0]   = i_byte;
                    2'd1: n_partial[15:8]  = i_byte;
                    2'd2: n_partial[23:16] = i_byte;
                    default: n_partial = r_partial;
                endcase
                n_pos = r_pos + 2'd1;
            end else begin
                n_pos = 2'd0;
                if (i_cfg.rle) begin
                    if (r_is_run) begin
                        n_left = 8'd0;
                    end else if (r_left != 8'd0) begin
                        n_left = r_left - 8'd1;
                    end
                    if (n_left == 8'd0) begin
                        n_expect_header = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_expect_header <= 1'b1;
            r_is_run        <= 1'b0;
            r_left          <= 8'd0;
            r_pos           <= 2'd0;
        end else begin
            r_expect_header <= n_expect_header;
            r_is_run        <= n_is_run;
            r_left          <= n_left;
            r_pos           <= n_pos;
        end
        r_partial <= n_partial;
    end

endmodule

// File: hdl/tga_fifo.sv
// Short first-word-fall-through queue of decoded pixel requests.
// Depends on tga_pkg for the entry type.
`timescale 1ns / 1ps
module tga_fifo import tga_pkg::*; #(
    parameter int Depth = QueueDepth
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_flush,
    input  logic i_push,
    input  t_evt i_data,
    input  logic i_pop,
    output t_evt o_data,
    output logic o_full,
    output logic o_empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

    t_evt            r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CntW-1:0] r_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == FullCnt);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == LastPtr) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == LastPtr) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hdl/tga_back.sv
// Back end: run clamping, image pixel count and the output register.
// Depends on tga_pkg and the assertion macros in the defines header.
`timescale 1ns / 1ps
module tga_back import tga_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_restart,
    input  logic [31:0] i_total,
    input  logic        i_empty,
    input  t_evt        i_evt,
    output logic        o_pop,
    input  logic        i_out_ready,
    output logic        o_out_valid,
    output logic [39:0] o_out_data,
    output logic        o_out_last
);

    `include "tga_rle_pixel_decoder_defines.svh"

    logic [31:0] r_remaining;
    logic        r_out_valid;
    logic        r_out_last;
    logic [31:0] r_out_color;
    logic [7:0]  r_out_repeat;
    logic [7:0]  repeat_cnt;
    logic        live;

    assign o_pop      = !i_empty && (!r_out_valid || i_out_ready);
    assign live       = (r_remaining != 32'd0);
    assign repeat_cnt = !i_evt.run ? 8'd1 :
                        ((r_remaining < {24'd0, i_evt.count}) ? r_remaining[7:0] : i_evt.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= 32'd0;
            r_out_valid <= 1'b0;
        end else if (i_restart) begin
            r_remaining <= i_total;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop && live) begin
                r_remaining <= r_remaining - {24'd0, repeat_cnt};
            end
            if (!r_out_valid || i_out_ready) begin
                r_out_valid <= o_pop && live;
            end
        end
        if (o_pop && live) begin
            r_out_color  <= {i_evt.alpha, i_evt.blue, i_evt.green, i_evt.red};
            r_out_repeat <= repeat_cnt;
            r_out_last   <= (r_remaining == {24'd0, repeat_cnt});
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {r_out_repeat, r_out_color};
    assign o_out_last  = r_out_last;

    `TGA_ASSERT_NXT(a_remaining_falls, i_clk, i_rst_n, !i_restart, r_remaining <= $past(r_remaining))
    `TGA_ASSERT_IMP(a_last_ends_image, i_clk, i_rst_n, r_out_valid && r_out_last, r_remaining == 32'd0)
    `TGA_ASSERT_IMP(a_repeat_range, i_clk, i_rst_n, r_out_valid, (r_out_repeat != 8'd0) && (r_out_repeat <= 8'd128))
    `TGA_ASSERT_NXT(a_restart_drops, i_clk, i_rst_n, i_restart, !r_out_valid)

endmodule
